FILE: hw/rtl/usfd_pkg.sv
package usfd_pkg;

    // digit width of the partial-product multipliers
    localparam int DIG_W = 32;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FALSE_EASTING   = 2'd0,
        CFG_CENTRAL_SCALE   = 2'd1,
        CFG_CURVATURE_COEFF = 2'd2
    } t_cfg_idx;

    // register widths
    localparam int FE_W   = 30;
    localparam int K0_W   = 32;
    localparam int QF_W   = 56;
    localparam int CFG_W  = 56;

    // register reset values
    localparam logic [FE_W-1:0] FE_RESET = 30'd500000000;
    localparam logic [K0_W-1:0] K0_RESET = 32'd1073312327;
    localparam logic [QF_W-1:0] QF_RESET = 56'd5484690000000000;

    // division by 35, one byte per step, via a scaled reciprocal
    localparam logic [5:0]  DIV_K      = 6'd35;
    localparam logic [14:0] DIV_RECIP  = 15'd29960;
    localparam int          DIV_STEPS  = 9;

    // square root and long division step counts
    localparam int SQ_STEPS = 65;
    localparam int DV_STEPS = 65;

    // distance and line scale clip values
    localparam logic [39:0] DIST_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

endpackage

FILE: hw/rtl/usfd_mul.sv
module usfd_mul
    import usfd_pkg::*;
#(
    parameter int AW = 62,
    parameter int BW = 71
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NA = (AW + DIG_W - 1) / DIG_W;
    localparam int NB = (BW + DIG_W - 1) / DIG_W;
    localparam int RW = DIG_W * (NB + 1);
    localparam int PW = DIG_W * (NA + NB);

    logic [NA*DIG_W-1:0]  w_a;
    logic [NB*DIG_W-1:0]  w_b;
    logic [2*DIG_W-1:0]   r_pp   [NA][NB];
    logic [RW-1:0]        w_even [NA];
    logic [RW-1:0]        w_odd  [NA];
    logic [RW-1:0]        r_row  [NA];
    logic [PW-1:0]        w_sum;
    logic [AW+BW-1:0]     r_p;

    assign w_a = (NA*DIG_W)'(i_a);
    assign w_b = (NB*DIG_W)'(i_b);

    // digit partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= (2*DIG_W)'(w_a[DIG_W*i +: DIG_W])
                                * (2*DIG_W)'(w_b[DIG_W*j +: DIG_W]);
                end
            end
        end
    end

    // even and odd digit products do not overlap, so each row is one add
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_even[i] = '0;
            w_odd[i]  = '0;
            for (int j = 0; j < NB; j++) begin
                if ((j % 2) == 0) begin
                    w_even[i][DIG_W*j +: 2*DIG_W] = r_pp[i][j];
                end else begin
                    w_odd[i][DIG_W*j +: 2*DIG_W] = r_pp[i][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                r_row[i] <= w_even[i] + w_odd[i];
            end
        end
    end

    // final sum of the shifted rows
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NA; i++) begin
            w_sum = w_sum + (PW'(r_row[i]) << (DIG_W*i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_sum[AW+BW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

FILE: hw/rtl/utm_scale_factor_distance.sv
// Line scale factor and true distance between two projected points.
// Input channel: i_valid / o_ready with the two eastings and northings (mm).
// Output channel: o_valid / i_ready with the true distance (mm), the line
// scale factor (Q2.30) and a flag that is set when either was clipped.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (false
// easting, central scale, curvature coefficient); other indexes are ignored.
// Write it only while no transfer is in flight.
// Throughput: one transfer per cycle unless i_ready stalls the output.
// Each result passes the 65-step square root of the grid distance followed by
// the 65-step long division by the scale factor, one bit per stage.
// All stages move together: when the output holds a result that i_ready does
// not take, the whole pipeline and o_ready hold, so nothing is lost or
// repeated. Reset clears the valid bits and loads the register defaults.
module utm_scale_factor_distance
    import usfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [29:0]       i_east_first,
    input  logic [33:0]       i_north_first,
    input  logic [29:0]       i_east_second,
    input  logic [33:0]       i_north_second,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [39:0]       o_true_distance,
    output logic [31:0]       o_line_scale,
    output logic              o_saturated
);

    localparam int LINE_ST = 24;
    localparam int SQ_END  = 4 + SQ_STEPS - 1;
    localparam int LN_DLY  = SQ_END - LINE_ST;
    localparam int LAT     = SQ_END + DV_STEPS + 1;

    logic [FE_W-1:0] r_fe;
    logic [K0_W-1:0] r_k0;
    logic [QF_W-1:0] r_qf;
    logic [1:LAT]    r_vld;
    logic            w_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe <= FE_RESET;
            r_k0 <= K0_RESET;
            r_qf <= QF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FALSE_EASTING:   r_fe <= i_cfg_data[FE_W-1:0];
                CFG_CENTRAL_SCALE:   r_k0 <= i_cfg_data[K0_W-1:0];
                CFG_CURVATURE_COEFF: r_qf <= i_cfg_data[QF_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance
    assign w_en    = !r_vld[LAT] || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: offsets from the central meridian and differences
    logic signed [30:0] w_a, w_b;
    logic signed [31:0] w_sab;
    logic signed [30:0] r1_a, r1_b;
    logic [30:0]        r1_us;
    logic [29:0]        r1_ud;
    logic [33:0]        r1_dn;

    assign w_a   = $signed({1'b0, i_east_first})  - $signed({1'b0, r_fe});
    assign w_b   = $signed({1'b0, i_east_second}) - $signed({1'b0, r_fe});
    assign w_sab = 32'(w_a) + 32'(w_b);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a  <= w_a;
            r1_b  <= w_b;
            r1_us <= w_sab[31] ? 31'(-w_sab) : w_sab[30:0];
            r1_ud <= (i_east_first >= i_east_second) ? i_east_first - i_east_second
                                                     : i_east_second - i_east_first;
            r1_dn <= (i_north_first >= i_north_second) ? i_north_first - i_north_second
                                                       : i_north_second - i_north_first;
        end
    end

    // stage 2: squares and cross product
    logic signed [61:0] r2_aa, r2_ab, r2_bb;
    logic [61:0]        r2_sb;
    logic [59:0]        r2_dx;
    logic [67:0]        r2_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_aa <= 62'(r1_a) * 62'(r1_a);
            r2_ab <= 62'(r1_a) * 62'(r1_b);
            r2_bb <= 62'(r1_b) * 62'(r1_b);
            r2_sb <= 62'(r1_us) * 62'(r1_us);
            r2_dx <= 60'(r1_ud) * 60'(r1_ud);
            r2_dy <= 68'(r1_dn) * 68'(r1_dn);
        end
    end

    // stage 3: quadratic term, positive and negative inner parts
    logic [62:0] w_quad;
    logic [61:0] r3_quad, r3_sb;
    logic [70:0] r3_pos;
    logic [62:0] r3_neg;
    logic [68:0] r3_dxy;

    assign w_quad = {r2_aa[61], r2_aa} + {r2_ab[61], r2_ab} + {r2_bb[61], r2_bb};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_quad <= w_quad[61:0];
            r3_sb   <= r2_sb;
            r3_pos  <= 71'({r2_dy, 2'b00}) + 71'(r2_sb);
            r3_neg  <= 63'({r2_dx, 2'b00}) + 63'({r2_dx, 1'b0});
            r3_dxy  <= 69'(r2_dx) + 69'(r2_dy);
        end
    end

    // stage 4: magnitude and sign of the inner factor
    logic        w_ineg;
    logic [70:0] r4_inner;
    logic [61:0] r4_sb, r4_quad;
    logic        r4_ineg;

    assign w_ineg = r3_pos < 71'(r3_neg);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ineg  <= w_ineg;
            r4_inner <= w_ineg ? 71'(r3_neg) - r3_pos : r3_pos - 71'(r3_neg);
            r4_sb    <= r3_sb;
            r4_quad  <= r3_quad;
        end
    end

    // correction product S * inner * 3qf
    logic [132:0] w_t1;
    logic [190:0] w_t2;
    logic [57:0]  w_q3;

    assign w_q3 = 58'({r_qf, 1'b0}) + 58'(r_qf);

    usfd_mul #(.AW(62), .BW(71)) u_mul_si (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r4_sb),
        .i_b   (r4_inner),
        .o_p   (w_t1)
    );

    usfd_mul #(.AW(58), .BW(133)) u_mul_q (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_q3),
        .i_b   (w_t1),
        .o_p   (w_t2)
    );

    // sign and quadratic term wait for the correction
    localparam int QD_DLY = 6 + DIV_STEPS;
    logic        r_ineg_dl [QD_DLY];
    logic [61:0] r_quad_dl [QD_DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ineg_dl[0] <= r4_ineg;
            r_quad_dl[0] <= r4_quad;
            for (int k = 1; k < QD_DLY; k++) begin
                r_ineg_dl[k] <= r_ineg_dl[k-1];
                r_quad_dl[k] <= r_quad_dl[k-1];
            end
        end
    end

    // division by 35, one byte per stage
    logic [71:0] r_c_x [DIV_STEPS];
    logic [71:0] r_c_q [DIV_STEPS];
    logic [5:0]  r_c_r [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div35
        logic [71:0] w_px, w_pq;
        logic [5:0]  w_pr;
        logic [13:0] w_cur, w_back;
        logic [28:0] w_prod;
        logic [7:0]  w_qd;

        if (k == 0) begin : g_first
            assign w_px = 72'(w_t2[190:120]);
            assign w_pq = '0;
            assign w_pr = '0;
        end else begin : g_next
            assign w_px = r_c_x[k-1];
            assign w_pq = r_c_q[k-1];
            assign w_pr = r_c_r[k-1];
        end

        assign w_cur  = {w_pr, w_px[8*(DIV_STEPS-1-k) +: 8]};
        assign w_prod = 29'(w_cur) * 29'(DIV_RECIP);
        assign w_qd   = w_prod[27:20];
        assign w_back = 14'(w_qd) * 14'(DIV_K);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c_x[k] <= w_px;
                r_c_q[k] <= {w_pq[63:0], w_qd};
                r_c_r[k] <= w_cur[5:0] - w_back[5:0];
            end
        end
    end

    // stage 20: signed sum of quadratic term and correction
    logic [71:0] w_cm, w_qx;
    logic [66:0] r20_tm;
    logic        r20_tneg;

    assign w_cm = r_c_q[DIV_STEPS-1];
    assign w_qx = 72'(r_quad_dl[QD_DLY-1]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_ineg_dl[QD_DLY-1]) begin
                r20_tm   <= 67'(w_qx + w_cm);
                r20_tneg <= 1'b0;
            end else if (w_cm > w_qx) begin
                r20_tm   <= 67'(w_cm - w_qx);
                r20_tneg <= 1'b1;
            end else begin
                r20_tm   <= 67'(w_qx - w_cm);
                r20_tneg <= 1'b0;
            end
        end
    end

    // scale increment q * T
    logic [122:0] w_up;
    logic         r_tneg_dl [3];

    usfd_mul #(.AW(56), .BW(67)) u_mul_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_qf),
        .i_b   (r20_tm),
        .o_p   (w_up)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tneg_dl[0] <= r20_tneg;
            r_tneg_dl[1] <= r_tneg_dl[0];
            r_tneg_dl[2] <= r_tneg_dl[1];
        end
    end

    // stage 24: line scale factor with clipping
    logic [32:0] w_um;
    logic [33:0] w_ksum;
    logic [31:0] r24_line;
    logic        r24_lsat;

    assign w_um   = w_up[122:90];
    assign w_ksum = 34'(r_k0) + 34'(w_um);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!r_tneg_dl[2]) begin
                if (w_ksum[33:32] != 2'b00) begin
                    r24_line <= LINE_MAX;
                    r24_lsat <= 1'b1;
                end else begin
                    r24_line <= w_ksum[31:0];
                    r24_lsat <= 1'b0;
                end
            end else if (w_um > 33'(r_k0)) begin
                r24_line <= '0;
                r24_lsat <= 1'b1;
            end else begin
                r24_line <= r_k0 - w_um[31:0];
                r24_lsat <= 1'b0;
            end
        end
    end

    // scale factor waits for the square root
    logic [31:0] r_ln_dl   [LN_DLY];
    logic        r_lsat_dl [LN_DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ln_dl[0]   <= r24_line;
            r_lsat_dl[0] <= r24_lsat;
            for (int k = 1; k < LN_DLY; k++) begin
                r_ln_dl[k]   <= r_ln_dl[k-1];
                r_lsat_dl[k] <= r_lsat_dl[k-1];
            end
        end
    end

    // grid distance: square root of (DX+DY) * 2^60, one root bit per stage
    logic [64:0] r_sq_root [SQ_STEPS];
    logic [66:0] r_sq_rem  [SQ_STEPS];
    logic [68:0] r_sq_m    [SQ_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
        logic [64:0]  w_proot;
        logic [66:0]  w_prem;
        logic [68:0]  w_pm;
        logic [129:0] w_mfull;
        logic [68:0]  w_cur, w_trial;

        if (s == 0) begin : g_first
            assign w_proot = '0;
            assign w_prem  = '0;
            assign w_pm    = r3_dxy;
        end else begin : g_next
            assign w_proot = r_sq_root[s-1];
            assign w_prem  = r_sq_rem[s-1];
            assign w_pm    = r_sq_m[s-1];
        end

        assign w_mfull = {1'b0, w_pm, 60'd0};
        assign w_cur   = {w_prem, w_mfull[2*(SQ_STEPS-1-s) +: 2]};
        assign w_trial = 69'({w_proot, 2'b01});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_m[s] <= w_pm;
                if (w_cur >= w_trial) begin
                    r_sq_rem[s]  <= 67'(w_cur - w_trial);
                    r_sq_root[s] <= {w_proot[63:0], 1'b1};
                end else begin
                    r_sq_rem[s]  <= w_cur[66:0];
                    r_sq_root[s] <= {w_proot[63:0], 1'b0};
                end
            end
        end
    end

    // true distance: long division of the root by the scale, one bit per stage
    logic [64:0] r_dv_q    [DV_STEPS];
    logic [31:0] r_dv_rem  [DV_STEPS];
    logic [64:0] r_dv_g    [DV_STEPS];
    logic [31:0] r_dv_line [DV_STEPS];
    logic        r_dv_lsat [DV_STEPS];

    for (genvar s = 0; s < DV_STEPS; s++) begin : g_div
        logic [64:0] w_pq, w_pg;
        logic [31:0] w_prem, w_pline;
        logic        w_plsat;
        logic [32:0] w_cur;

        if (s == 0) begin : g_first
            assign w_pq    = '0;
            assign w_prem  = '0;
            assign w_pg    = r_sq_root[SQ_STEPS-1];
            assign w_pline = r_ln_dl[LN_DLY-1];
            assign w_plsat = r_lsat_dl[LN_DLY-1];
        end else begin : g_next
            assign w_pq    = r_dv_q[s-1];
            assign w_prem  = r_dv_rem[s-1];
            assign w_pg    = r_dv_g[s-1];
            assign w_pline = r_dv_line[s-1];
            assign w_plsat = r_dv_lsat[s-1];
        end

        assign w_cur = {w_prem, w_pg[DV_STEPS-1-s]};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_g[s]    <= w_pg;
                r_dv_line[s] <= w_pline;
                r_dv_lsat[s] <= w_plsat;
                if (w_cur >= {1'b0, w_pline}) begin
                    r_dv_rem[s] <= 32'(w_cur - {1'b0, w_pline});
                    r_dv_q[s]   <= {w_pq[63:0], 1'b1};
                end else begin
                    r_dv_rem[s] <= w_cur[31:0];
                    r_dv_q[s]   <= {w_pq[63:0], 1'b0};
                end
            end
        end
    end

    // output register with distance clipping
    logic [64:0] w_fq;
    logic [31:0] w_fline;
    logic [39:0] r_o_dist;
    logic [31:0] r_o_line;
    logic        r_o_sat;

    assign w_fq    = r_dv_q[DV_STEPS-1];
    assign w_fline = r_dv_line[DV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_line <= w_fline;
            if (w_fline == '0 || w_fq[64:40] != '0) begin
                r_o_dist <= DIST_MAX;
                r_o_sat  <= 1'b1;
            end else begin
                r_o_dist <= w_fq[39:0];
                r_o_sat  <= r_dv_lsat[DV_STEPS-1];
            end
        end
    end

    assign o_valid         = r_vld[LAT];
    assign o_true_distance = r_o_dist;
    assign o_line_scale    = r_o_line;
    assign o_saturated     = r_o_sat;

    // a zero scale factor always reports clipping
    a_zero_line_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_saturated |-> o_line_scale != '0)
        else $error("zero scale factor without saturation flag");

    // the first valid bit follows the input transfer
    a_vld_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> r_vld[1] == $past(i_valid))
        else $error("input transfer not tracked by valid bit");

    // square root remainder stays within twice the root
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SQ_END] |-> r_sq_rem[SQ_STEPS-1] <= 67'({r_sq_root[SQ_STEPS-1], 1'b0}))
        else $error("square root remainder out of bound");

    // division remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] && r_dv_line[DV_STEPS-1] != '0
            |-> r_dv_rem[DV_STEPS-1] < r_dv_line[DV_STEPS-1])
        else $error("division remainder not below scale factor");

    // a stall freezes the pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_sq_root[SQ_STEPS-1]) && $stable(r_o_dist))
        else $error("pipeline moved during stall");

endmodule

FILE: sim/utm_scale_factor_distance_tb.sv
`timescale 1ns / 100ps

module utm_scale_factor_distance_tb
    import usfd_pkg::*;
();

    // index outside the register list, must be ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [29:0] E_MAX = 30'h3FFF_FFFF;
    localparam logic [33:0] N_MAX = 34'h3_FFFF_FFFF;

    typedef struct packed {
        logic [29:0] e1;
        logic [33:0] n1;
        logic [29:0] e2;
        logic [33:0] n2;
    } t_points;

    typedef struct packed {
        logic [39:0] distance;
        logic [31:0] line;
        logic        sat;
    } t_line_result;

    // line scale and distance predictor and store of pending results
    class line_scale_board;
        logic [FE_W-1:0] fe;
        logic [K0_W-1:0] k0;
        logic [QF_W-1:0] qf;
        t_line_result    pending[$];
        int              errors;

        function new();
            fe = FE_RESET;
            k0 = K0_RESET;
            qf = QF_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_FALSE_EASTING:   fe = data[FE_W-1:0];
                CFG_CENTRAL_SCALE:   k0 = data[K0_W-1:0];
                CFG_CURVATURE_COEFF: qf = data[QF_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_points p);
            longint a, b, quad, sm;
            longint unsigned us, ud, dn;
            logic [255:0] ssq, dx, dy, pos, neg, inner, corr, tmag, umag;
            logic [255:0] sum, rad, g, cand, quo;
            bit ineg, tneg;
            t_line_result r;
            a = longint'(p.e1) - longint'(fe);
            b = longint'(p.e2) - longint'(fe);
            quad = a * a + a * b + b * b;
            sm = a + b;
            us = (sm < 0) ? -sm : sm;
            ud = (p.e1 > p.e2) ? p.e1 - p.e2 : p.e2 - p.e1;
            dn = (p.n1 > p.n2) ? p.n1 - p.n2 : p.n2 - p.n1;
            ssq = 256'(us) * 256'(us);
            dx = 256'(ud) * 256'(ud);
            dy = 256'(dn) * 256'(dn);
            r.sat = 1'b0;

            // correction term, sign carried separately
            pos = 4 * dy + ssq;
            neg = 6 * dx;
            ineg = pos < neg;
            inner = ineg ? neg - pos : pos - neg;
            corr = ((ssq * inner * (256'(qf) * 3)) >> 120) / 35;

            // quadratic plus correction
            tneg = 1'b0;
            if (!ineg) begin
                tmag = 256'(quad) + corr;
            end else if (corr > 256'(quad)) begin
                tmag = corr - 256'(quad);
                tneg = 1'b1;
            end else begin
                tmag = 256'(quad) - corr;
            end
            umag = (256'(qf) * tmag) >> 90;

            // scale factor with clipping
            if (!tneg) begin
                sum = umag + 256'(k0);
                if (sum > 256'(LINE_MAX)) begin
                    r.line = LINE_MAX;
                    r.sat = 1'b1;
                end else begin
                    r.line = sum[31:0];
                end
            end else if (umag > 256'(k0)) begin
                r.line = '0;
                r.sat = 1'b1;
            end else begin
                r.line = k0 - umag[31:0];
            end

            // grid distance in Q30 by bitwise square root
            rad = (dx + dy) << 60;
            g = '0;
            for (int bitpos = 66; bitpos >= 0; bitpos--) begin
                cand = g | (256'(1) << bitpos);
                if (cand * cand <= rad)
                    g = cand;
            end

            if (r.line == 0) begin
                r.distance = DIST_MAX;
                r.sat = 1'b1;
            end else begin
                quo = g / 256'(r.line);
                if (quo > 256'(DIST_MAX)) begin
                    r.distance = DIST_MAX;
                    r.sat = 1'b1;
                end else begin
                    r.distance = quo[39:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_line_result got);
            t_line_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result distance=%0d line=%0d sat=%0b",
                         $time, got.distance, got.line, got.sat);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance) begin
                $display("%0t: true_distance expected %0d actual %0d",
                         $time, want.distance, got.distance);
                errors++;
            end
            if (got.line !== want.line) begin
                $display("%0t: line_scale expected %0d actual %0d",
                         $time, want.line, got.line);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [29:0]       i_east_first;
    logic [33:0]       i_north_first;
    logic [29:0]       i_east_second;
    logic [33:0]       i_north_second;
    logic              o_valid;
    logic              i_ready;
    logic [39:0]       o_true_distance;
    logic [31:0]       o_line_scale;
    logic              o_saturated;

    line_scale_board board;
    bit              calm;

    utm_scale_factor_distance u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_east_first   (i_east_first),
        .i_north_first  (i_north_first),
        .i_east_second  (i_east_second),
        .i_north_second (i_north_second),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_true_distance(o_true_distance),
        .o_line_scale   (o_line_scale),
        .o_saturated    (o_saturated)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side: random stall bursts
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result('{o_true_distance, o_line_scale, o_saturated});
    end

    // runaway guard
    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_points(t_points p);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_east_first = p.e1;
        i_north_first = p.n1;
        i_east_second = p.e2;
        i_north_second = p.n2;
        do @(posedge i_clk); while (!o_ready);
        board.note_input(p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    function automatic logic [29:0] rand_east();
        logic [29:0] off;
        case ($urandom_range(0, 5))
            0: return 30'($urandom());
            1: return E_MAX;
            2: return '0;
            default: begin
                off = 30'($urandom_range(0, 400000000));
                return $urandom_range(0, 1) ? board.fe + off : board.fe - off;
            end
        endcase
    endfunction

    function automatic logic [33:0] rand_north();
        case ($urandom_range(0, 5))
            0: return 34'({$urandom(), $urandom()});
            1: return N_MAX;
            2: return '0;
            default: return {2'($urandom_range(0, 2)), $urandom()};
        endcase
    endfunction

    task automatic random_pairs(int count);
        t_points p;
        for (int k = 0; k < count; k++) begin
            p.e1 = rand_east();
            p.n1 = rand_north();
            // mostly nearby second point, sometimes anywhere
            if ($urandom_range(0, 2) == 0) begin
                p.e2 = rand_east();
                p.n2 = rand_north();
            end else begin
                p.e2 = p.e1 + 30'($urandom_range(0, 20000000)) - 30'd10000000;
                p.n2 = p.n1 + 34'($urandom_range(0, 20000000)) - 34'd10000000;
            end
            send_points(p);
        end
    endtask

    task automatic directed_pairs();
        t_points p;
        logic [29:0] fe;
        fe = board.fe;
        send_points('{'0, '0, '0, '0});
        send_points('{E_MAX, N_MAX, E_MAX, N_MAX});
        send_points('{'0, '0, E_MAX, N_MAX});
        send_points('{E_MAX, '0, '0, N_MAX});
        send_points('{fe, '0, fe, N_MAX});
        send_points('{fe, 34'd1000, fe, 34'd1000});
        send_points('{fe + 30'd1000, 34'd5000000000, fe - 30'd1000, 34'd5000000000});
        send_points('{30'd1000000000, 34'd10000000000, '0, '0});
        send_points('{fe + 30'd300000000, 34'd123456789, fe + 30'd300001000,
                      34'd123457789});
        p.e1 = 30'h2AAA_AAAA;
        p.n1 = 34'h2_AAAA_AAAA;
        p.e2 = 30'h1555_5555;
        p.n2 = 34'h1_5555_5555;
        send_points(p);
    endtask

    initial begin
        board = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FALSE_EASTING;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_east_first = '0;
        i_north_first = '0;
        i_east_second = '0;
        i_north_second = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset defaults
        directed_pairs();
        random_pairs(250);
        drain();

        // scale above range
        write_reg(CFG_FALSE_EASTING, '0);
        write_reg(CFG_CENTRAL_SCALE, 56'(LINE_MAX));
        write_reg(CFG_CURVATURE_COEFF, {QF_W{1'b1}});
        directed_pairs();
        random_pairs(100);
        drain();

        // zero scale factor, spare index ignored
        write_reg(CFG_FALSE_EASTING, 56'(E_MAX));
        write_reg(CFG_CENTRAL_SCALE, '0);
        write_reg(CFG_CURVATURE_COEFF, '0);
        write_reg(CFG_SPARE, {CFG_W{1'b1}});
        directed_pairs();
        random_pairs(60);
        drain();

        // tiny scale factor pushes distances over range
        write_reg(CFG_CENTRAL_SCALE, 56'd1);
        write_reg(CFG_FALSE_EASTING, 56'd500000000);
        directed_pairs();
        random_pairs(100);
        drain();

        // large negative correction drives scale below zero
        write_reg(CFG_CENTRAL_SCALE, 56'd1000);
        write_reg(CFG_CURVATURE_COEFF, {QF_W{1'b1}});
        random_pairs(150);
        drain();

        // random settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_FALSE_EASTING, 56'($urandom_range(0, 1000000000)));
            write_reg(CFG_CENTRAL_SCALE, 56'($urandom()));
            write_reg(CFG_CURVATURE_COEFF, {$urandom(), $urandom()});
            random_pairs(80);
            drain();
        end

        // realistic settings, no idling at the end
        write_reg(CFG_FALSE_EASTING, 56'(FE_RESET));
        write_reg(CFG_CENTRAL_SCALE, 56'(K0_RESET));
        write_reg(CFG_CURVATURE_COEFF, 56'(QF_RESET));
        random_pairs(100);
        calm = 1'b1;
        random_pairs(100);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
